>>> src/imv_pkg.sv
// Package for the IBAN mod-97 validator: sequencer states, character codes
// and the one-digit mod-97 step shared by the datapath.
// Depends on nothing; used by src/iban_mod97_validator.sv.
package imv_pkg;

  // Checksum arithmetic.
  localparam int unsigned MOD_BASE   = 97;
  localparam int unsigned RADIX      = 10;
  localparam int unsigned MIN_LENGTH = 15;
  localparam int unsigned HEAD_COUNT = 4;
  localparam int unsigned CNT_W      = $clog2(HEAD_COUNT + 1);
  localparam int unsigned REM_W      = 7;
  localparam int unsigned VAL_W      = 6;  // character value 0..35
  localparam int unsigned DIG_W      = 4;  // one decimal digit
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a transaction
    ST_UNIT,    // pushing the units digit of a letter
    ST_REPLAY,  // replaying the buffered head characters
    ST_DONE     // loading the result register
  } state_e;

  // One decimal digit into the remainder: (rem * 10 + d) mod 97.
  // The sum stays below 16 * 97, so four conditional subtractions reduce it.
  function automatic logic [REM_W-1:0] push_mod97(logic [REM_W-1:0] rem,
                                                  logic [DIG_W-1:0] d);
    logic [9:0] x;
    x = ({3'b000, rem} << 3) + ({3'b000, rem} << 1) + {6'b000000, d};
    for (int k = 3; k >= 0; k--) begin
      if (x >= 10'(MOD_BASE << k)) begin
        x = x - 10'(MOD_BASE << k);
      end
    end
    return x[REM_W-1:0];
  endfunction

  // Tens digit of a letter value 10..35.
  function automatic logic [DIG_W-1:0] tens_of(logic [VAL_W-1:0] v);
    logic [DIG_W-1:0] t;
    if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'(RADIX)) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  // First digit pushed for a value: the digit itself, or a letter's tens digit.
  function automatic logic [DIG_W-1:0] first_digit(logic [VAL_W-1:0] v);
    logic [DIG_W-1:0] f;
    if (v < 6'(RADIX)) begin
      f = v[DIG_W-1:0];
    end else begin
      f = tens_of(v);
    end
    return f;
  endfunction

  // Units digit of a letter value 10..35.
  function automatic logic [DIG_W-1:0] units_of(logic [VAL_W-1:0] v);
    logic [DIG_W-1:0] t;
    logic [VAL_W-1:0] u;
    t = tens_of(v);
    u = v - (({2'b00, t} << 3) + ({2'b00, t} << 1));
    return u[DIG_W-1:0];
  endfunction

endpackage

>>> src/iban_mod97_validator.sv
// Streaming IBAN checker: character filtering, head buffer and a digit-serial
// mod-97 remainder driven by a small sequencer.
// Depends on src/imv_pkg.sv.
//
// Throughput: a space, a skipped byte, a head character or a digit is handled in ST_IDLE alone;
// a letter after the fourth kept character also passes ST_UNIT, as the mod-97 unit folds one decimal digit
// a cycle. An end transaction goes straight to ST_DONE on a failed format check, and on a pass
// through ST_REPLAY and ST_UNIT before it (the head replays as six digits); ST_DONE raises the master-side valid. The
// input accepts again once the result is loaded; a result still waiting holds it off.
// Reset is asynchronous and active low; it clears the sequencer, counts, flags and out valid.
module iban_mod97_validator #(
  parameter int unsigned MAX_LENGTH = 34
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Character stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] is_end
  // Result stream, one transaction per end item.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] valid_res, [7:1] zero
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);

  imv_pkg::state_e state_q, state_d;

  // Count of kept characters; it stops counting once the string has failed.
  logic [LEN_W-1:0] len_q, len_d;
  logic [imv_pkg::REM_W-1:0] rem_q, rem_d;
  logic failed_q, failed_d;
  // Set when the end item passed the format check and the replay runs.
  logic pass_q, pass_d;
  // Distinguishes a letter's units digit during replay from one during input.
  logic replay_q, replay_d;
  logic [imv_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [imv_pkg::DIG_W-1:0] units_q, units_d;
  logic out_valid_q, out_valid_d;
  logic out_res_q, out_res_d;

  // Head buffer holds the values (0..35) of the first four kept characters.
  logic [imv_pkg::VAL_W-1:0] head_q [imv_pkg::HEAD_COUNT];
  logic                      head_we;
  logic [1:0]                head_waddr;
  logic [imv_pkg::VAL_W-1:0] head_wdata;

  // Incoming character, folded to uppercase and classified.
  logic [imv_pkg::CHAR_W-1:0] char_up;
  logic                       in_digit;
  logic                       in_upper;
  logic [imv_pkg::VAL_W-1:0]  in_val;
  logic                       head_ok;
  logic [imv_pkg::VAL_W-1:0]  replay_val;
  logic                       accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tdata >= imv_pkg::CHAR_LOWER_A && s_axis_tdata <= imv_pkg::CHAR_LOWER_Z) begin
      char_up = s_axis_tdata - imv_pkg::CASE_OFFSET;
    end else begin
      char_up = s_axis_tdata;
    end
  end

  assign in_digit = (char_up >= imv_pkg::CHAR_ZERO) && (char_up <= imv_pkg::CHAR_NINE);
  assign in_upper = (char_up >= imv_pkg::CHAR_UPPER_A) && (char_up <= imv_pkg::CHAR_UPPER_Z);

  always_comb begin
    logic [imv_pkg::CHAR_W-1:0] diff;
    if (in_digit) begin
      diff = char_up - imv_pkg::CHAR_ZERO;
    end else begin
      diff = char_up - imv_pkg::CHAR_UPPER_A + 8'(imv_pkg::RADIX);
    end
    in_val = diff[imv_pkg::VAL_W-1:0];
  end

  // Country code must be two letters, check digits two digits.
  assign head_ok = (head_q[0] >= 6'(imv_pkg::RADIX)) && (head_q[1] >= 6'(imv_pkg::RADIX)) &&
                   (head_q[2] <  6'(imv_pkg::RADIX)) && (head_q[3] <  6'(imv_pkg::RADIX));

  assign replay_val = head_q[cnt_q[1:0]];

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rem_d       = rem_q;
    failed_d    = failed_q;
    pass_d      = pass_q;
    replay_d    = replay_q;
    cnt_d       = cnt_q;
    units_d     = units_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    head_we     = 1'b0;
    head_waddr  = len_q[1:0];
    head_wdata  = in_val;

    // The result register empties on its own handshake.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      imv_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            // End of string: check the format, then replay or report a fail.
            if (!failed_q && len_q >= LEN_W'(imv_pkg::MIN_LENGTH) && head_ok) begin
              pass_d   = 1'b1;
              replay_d = 1'b1;
              cnt_d    = '0;
              state_d  = imv_pkg::ST_REPLAY;
            end else begin
              pass_d  = 1'b0;
              state_d = imv_pkg::ST_DONE;
            end
          end else if (!failed_q && s_axis_tdata != imv_pkg::CHAR_SPACE) begin
            if (!in_digit && !in_upper) begin
              failed_d = 1'b1;
            end else if (len_q >= LEN_W'(MAX_LENGTH)) begin
              failed_d = 1'b1;
            end else begin
              len_d = len_q + 1'b1;
              if (len_q < LEN_W'(imv_pkg::HEAD_COUNT)) begin
                head_we = 1'b1;
              end else begin
                rem_d = imv_pkg::push_mod97(rem_q, imv_pkg::first_digit(in_val));
                if (in_upper) begin
                  units_d  = imv_pkg::units_of(in_val);
                  replay_d = 1'b0;
                  state_d  = imv_pkg::ST_UNIT;
                end
              end
            end
          end
        end
      end

      imv_pkg::ST_UNIT: begin
        rem_d = imv_pkg::push_mod97(rem_q, units_q);
        if (!replay_q) begin
          state_d = imv_pkg::ST_IDLE;
        end else if (cnt_q == imv_pkg::CNT_W'(imv_pkg::HEAD_COUNT)) begin
          state_d = imv_pkg::ST_DONE;
        end else begin
          state_d = imv_pkg::ST_REPLAY;
        end
      end

      imv_pkg::ST_REPLAY: begin
        rem_d = imv_pkg::push_mod97(rem_q, imv_pkg::first_digit(replay_val));
        cnt_d = cnt_q + 1'b1;
        if (replay_val >= 6'(imv_pkg::RADIX)) begin
          units_d = imv_pkg::units_of(replay_val);
          state_d = imv_pkg::ST_UNIT;
        end else if (cnt_q == imv_pkg::CNT_W'(imv_pkg::HEAD_COUNT - 1)) begin
          state_d = imv_pkg::ST_DONE;
        end else begin
          state_d = imv_pkg::ST_REPLAY;
        end
      end

      imv_pkg::ST_DONE: begin
        // Wait for room in the result register, then start a new string.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_res_d   = pass_q && (rem_q == imv_pkg::REM_W'(1));
          len_d       = '0;
          rem_d       = '0;
          failed_d    = 1'b0;
          pass_d      = 1'b0;
          replay_d    = 1'b0;
          state_d     = imv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = imv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imv_pkg::ST_IDLE;
      len_q       <= '0;
      rem_q       <= '0;
      failed_q    <= 1'b0;
      pass_q      <= 1'b0;
      replay_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      failed_q    <= failed_d;
      pass_q      <= pass_d;
      replay_q    <= replay_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    units_q   <= units_d;
    out_res_q <= out_res_d;
    if (head_we) begin
      head_q[head_waddr] <= head_wdata;
    end
  end

  assign s_axis_tready = (state_q == imv_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, out_res_q};

  // The remainder stays reduced after every digit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < imv_pkg::REM_W'(imv_pkg::MOD_BASE))
    else $error("remainder left unreduced");

  // The kept length never passes the configured maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LENGTH))
    else $error("kept length beyond maximum");

  // A new result is only ever loaded from the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !m_axis_tready)) |->
      $past(state_q == imv_pkg::ST_DONE))
    else $error("result loaded outside done state");

  // The replay counter never runs past the head buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= imv_pkg::CNT_W'(imv_pkg::HEAD_COUNT))
    else $error("replay counter overrun");

  // Replay only happens for strings that passed the format check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imv_pkg::ST_REPLAY) |-> (pass_q && replay_q))
    else $error("replay without a passing format check");

endmodule
